### hdl/optt_pkg.sv
// Shared types and constants of the one-shot and periodic timer table.
package optt_pkg;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_ONESHOT   = 3'd1,
        ACT_PERIODIC  = 3'd2,
        ACT_CLEAR_ID  = 3'd3,
        ACT_CLEAR_ALL = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        EV_FIRED   = 2'd0,
        EV_CREATED = 2'd1,
        EV_FAILED  = 2'd2,
        EV_CLEARED = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_IDSTEP,
        S_IDCHECK
    } t_state;

    typedef struct packed {
        t_action            action;
        logic [31:0]        now_us;
        logic [31:0]        period_us;
        logic signed [31:0] user_value;
        logic signed [31:0] target_id;
    } t_cmd;

    localparam logic signed [31:0] ONESHOT_BASE  = 32'sd1000;
    localparam logic signed [31:0] PERIODIC_BASE = -32'sd1000;
    localparam logic signed [31:0] ID_LIMIT      = 32'sd2147483645;

endpackage

### hdl/optt_front.sv
// Front end: accepts input transfers, drops unused actions and queues commands.
module optt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  optt_pkg::t_cmd i_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output optt_pkg::t_cmd o_cmd
);
    import optt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       known;
    logic       push;
    logic       pop;

    always_comb begin
        unique case (i_cmd.action)
            ACT_TICK, ACT_ONESHOT, ACT_PERIODIC, ACT_CLEAR_ID, ACT_CLEAR_ALL: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && known;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

### hdl/optt_back.sv
// Back end: slot table, tick scan, id assignment, clears and the result register.
module optt_back #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  optt_pkg::t_cmd        i_cmd,
    output logic                  o_valid,
    input  logic                  i_ready,
    output optt_pkg::t_event      o_event_res,
    output logic signed [31:0]    o_timer_id,
    output logic signed [31:0]    o_fired_value,
    output logic [4:0]            o_active_count,
    output logic                  o_last
);
    import optt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]   r_active;
    logic [SLOTS-1:0]   r_periodic;
    logic [31:0]        r_start  [SLOTS];
    logic [31:0]        r_period [SLOTS];
    logic [31:0]        r_ident  [SLOTS];
    logic [31:0]        r_value  [SLOTS];
    logic signed [31:0] r_next_os;
    logic signed [31:0] r_next_per;
    logic [CW-1:0]      r_count;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_free;

    logic          r_held_valid;
    t_event        r_held_ev;
    logic [31:0]   r_held_id;
    logic [31:0]   r_held_val;
    logic [CW-1:0] r_held_cnt;

    logic          r_ovalid;
    t_event        r_oev;
    logic [31:0]   r_oid;
    logic [31:0]   r_oval;
    logic [CW-1:0] r_ocnt;
    logic          r_olast;

    logic          emit_ok;
    logic          due;
    logic          stall;
    logic          last_idx;
    logic          full;
    logic [IW-1:0] free_idx;
    logic          match_found;
    logic [IW-1:0] match_idx;
    logic          is_oneshot;
    logic [31:0]   cand;
    logic          cand_used;
    logic          out_load;

    assign emit_ok    = !r_ovalid || i_ready;
    assign due        = r_active[r_idx] && ((r_cmd.now_us - r_start[r_idx]) >= r_period[r_idx]);
    assign stall      = due && r_held_valid && !emit_ok;
    assign last_idx   = (r_idx == IW'(SLOTS - 1));
    assign full       = &r_active;
    assign is_oneshot = (r_cmd.action == ACT_ONESHOT);
    assign cand       = is_oneshot ? r_next_os : r_next_per;
    // The output register takes the held result this cycle.
    assign out_load   = ((r_state == S_SCAN) && !stall && due && r_held_valid)
                        || ((r_state == S_FLUSH) && r_held_valid && emit_ok);

    // Lowest free slot, lowest slot holding the target id, and the id-in-use check.
    always_comb begin
        free_idx    = '0;
        match_found = 1'b0;
        match_idx   = '0;
        cand_used   = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_idx = IW'(i);
            end
            if (r_active[i] && (r_ident[i] == i_cmd.target_id)) begin
                match_found = 1'b1;
                match_idx   = IW'(i);
            end
            if (r_active[i] && (r_ident[i] == cand)) begin
                cand_used = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    priority case (i_cmd.action)
                        ACT_TICK:                  n_state = S_SCAN;
                        ACT_ONESHOT, ACT_PERIODIC: n_state = full ? S_FLUSH : S_IDSTEP;
                        ACT_CLEAR_ID, ACT_CLEAR_ALL: n_state = S_FLUSH;
                        default:                   n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (!stall && last_idx) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_held_valid || emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            S_IDSTEP: n_state = S_IDCHECK;
            S_IDCHECK: n_state = cand_used ? S_IDSTEP : S_FLUSH;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd_ready    = (r_state == S_IDLE);
        o_valid        = r_ovalid;
        o_event_res    = r_oev;
        o_timer_id     = r_oid;
        o_fired_value  = r_oval;
        o_active_count = 5'(r_ocnt);
        o_last         = r_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= '0;
            r_count      <= '0;
            r_next_os    <= ONESHOT_BASE;
            r_next_per   <= PERIODIC_BASE;
            r_held_valid <= 1'b0;
            r_ovalid     <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_cmd_valid) begin
                        priority case (i_cmd.action)
                            ACT_ONESHOT, ACT_PERIODIC: begin
                                if (full) begin
                                    r_held_valid <= 1'b1;
                                    r_held_ev    <= EV_FAILED;
                                    r_held_id    <= '0;
                                    r_held_val   <= '0;
                                    r_held_cnt   <= r_count;
                                end
                            end
                            ACT_CLEAR_ID: begin
                                r_held_valid <= 1'b1;
                                r_held_ev    <= EV_CLEARED;
                                r_held_id    <= i_cmd.target_id;
                                r_held_val   <= '0;
                                if ((i_cmd.target_id != 32'sd0) && match_found) begin
                                    r_active[match_idx] <= 1'b0;
                                    r_count             <= r_count - CW'(1);
                                    r_held_cnt          <= r_count - CW'(1);
                                end else begin
                                    r_held_cnt <= r_count;
                                end
                            end
                            ACT_CLEAR_ALL: begin
                                r_active     <= '0;
                                r_count      <= '0;
                                r_held_valid <= 1'b1;
                                r_held_ev    <= EV_CLEARED;
                                r_held_id    <= '0;
                                r_held_val   <= '0;
                                r_held_cnt   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        if (due) begin
                            if (r_held_valid) begin
                                r_ovalid <= 1'b1;
                                r_oev    <= r_held_ev;
                                r_oid    <= r_held_id;
                                r_oval   <= r_held_val;
                                r_ocnt   <= r_held_cnt;
                                r_olast  <= 1'b0;
                            end
                            r_held_valid <= 1'b1;
                            r_held_ev    <= EV_FIRED;
                            r_held_id    <= r_ident[r_idx];
                            r_held_val   <= r_value[r_idx];
                            if (r_periodic[r_idx]) begin
                                r_held_cnt <= r_count;
                            end else begin
                                r_active[r_idx] <= 1'b0;
                                r_count         <= r_count - CW'(1);
                                r_held_cnt      <= r_count - CW'(1);
                            end
                        end
                        if (!last_idx) begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (r_held_valid && emit_ok) begin
                        r_ovalid     <= 1'b1;
                        r_oev        <= r_held_ev;
                        r_oid        <= r_held_id;
                        r_oval       <= r_held_val;
                        r_ocnt       <= r_held_cnt;
                        r_olast      <= 1'b1;
                        r_held_valid <= 1'b0;
                    end
                end
                S_IDSTEP: begin
                    if (is_oneshot) begin
                        r_next_os <= ((r_next_os > ID_LIMIT) ? ONESHOT_BASE : r_next_os) + 32'sd1;
                    end else begin
                        r_next_per <= ((r_next_per < -ID_LIMIT) ? PERIODIC_BASE : r_next_per)
                                      - 32'sd1;
                    end
                end
                S_IDCHECK: begin
                    if (!cand_used) begin
                        r_active[r_free] <= 1'b1;
                        r_count          <= r_count + CW'(1);
                        r_held_valid     <= 1'b1;
                        r_held_ev        <= EV_CREATED;
                        r_held_id        <= cand;
                        r_held_val       <= '0;
                        r_held_cnt       <= r_count + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Slot payload needs no reset; it is only read while the slot is active.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd  <= i_cmd;
            r_free <= free_idx;
        end
        if (r_state == S_SCAN && !stall && due && r_periodic[r_idx]) begin
            r_start[r_idx] <= r_cmd.now_us;
        end
        if (r_state == S_IDCHECK && !cand_used) begin
            r_periodic[r_free] <= !is_oneshot;
            r_start[r_free]    <= r_cmd.now_us;
            r_period[r_free]   <= r_cmd.period_us;
            r_ident[r_free]    <= cand;
            r_value[r_free]    <= r_cmd.user_value;
        end
    end

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_active) == int'(r_count))
        else $error("active count disagrees with active slots");

    a_free_slot_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDSTEP || r_state == S_IDCHECK) |-> !r_active[r_free])
        else $error("chosen free slot became active during id search");

    a_fire_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && due && r_held_valid && !emit_ok) |=>
        (r_held_valid && $stable(r_idx)))
        else $error("pending fire dropped while the output stalled");

endmodule

### hdl/oneshot_periodic_timer_table_top.sv
// Top level of the one-shot and periodic timer table.
// The input channel (i_valid / o_ready) carries one command per transfer: a tick
// with the current time, a one-shot or periodic create, a clear of one id, or a
// clear of all timers. Commands with unused action codes are taken and dropped.
// The front end holds a two-entry command queue ahead of the slot engine, so
// the sender can keep going while the engine works on an earlier command.
// The output channel (o_valid / i_ready) carries results from a single output
// register; o_last marks the final result of each command that yields one.
// A tick walks the slot table one slot per cycle while the receiver does not
// stall; every due slot produces a fire result. A create steps the id counter
// and checks the new id, repeating both while that id is already in use.
// Clears and failed creates go straight to the flush step. A new command starts
// only after the previous one has handed its last result to the output register.
// On a receiver stall the engine holds its result and halts the scan at a due slot.
// Reset is synchronous and active low: all slots become free, the id counters
// return to their start values and the queue and output register are emptied.
module oneshot_periodic_timer_table_top #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_action,
    input  logic [31:0]        i_now_us,
    input  logic [31:0]        i_period_us,
    input  logic signed [31:0] i_user_value,
    input  logic signed [31:0] i_target_id,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_event_res,
    output logic signed [31:0] o_timer_id,
    output logic signed [31:0] o_fired_value,
    output logic [4:0]         o_active_count,
    output logic               o_last
);
    import optt_pkg::*;

    t_cmd   in_cmd;
    t_cmd   q_cmd;
    logic   q_valid;
    logic   q_ready;
    t_event ev;

    // Pack the input fields into one command word for the queue.
    always_comb begin
        in_cmd.action     = t_action'(i_action);
        in_cmd.now_us     = i_now_us;
        in_cmd.period_us  = i_period_us;
        in_cmd.user_value = i_user_value;
        in_cmd.target_id  = i_target_id;
    end

    optt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (in_cmd),
        .o_cmd_valid (q_valid),
        .i_cmd_ready (q_ready),
        .o_cmd       (q_cmd)
    );

    optt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (q_valid),
        .o_cmd_ready    (q_ready),
        .i_cmd          (q_cmd),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_res    (ev),
        .o_timer_id     (o_timer_id),
        .o_fired_value  (o_fired_value),
        .o_active_count (o_active_count),
        .o_last         (o_last)
    );

    assign o_event_res = 2'(ev);

endmodule
